/* rtl/core/tld_pkg.sv */
// tld_pkg: shared types and constants for the terminal line discipline buffer.
// Holds the sequencer state, the action and register codes, and the result record.
// No dependencies.
`default_nettype none

package tld_pkg;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  // Configuration register indexes
  localparam logic CFG_ECHO_ENABLE    = 1'b0;
  localparam logic CFG_CANONICAL_MODE = 1'b1;

  typedef enum logic {
    ACT_KEY  = 1'b0,
    ACT_READ = 1'b1
  } tld_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFER_RD,
    ST_XFER_WR,
    ST_RD_WAIT,
    ST_RESP
  } tld_state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_empty;
    logic       line_end;
    logic       char_dropped;
  } tld_result_t;

endpackage

`default_nettype wire

/* rtl/core/tld_ring.sv */
// tld_ring: character store of one ring, one write port and one read port.
// Read data is registered and appears in the cycle after the read request.
// No package dependencies.
`default_nettype none

module tld_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/tld_ctrl.sv */
// tld_ctrl: sequencer for the line discipline buffer; owns the ring pointers,
// drives both ring ports and builds one result per transaction.
// Depends on tld_pkg.
`default_nettype none

module tld_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                echo_enable,
  input  wire logic                canonical_mode,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_action,
  input  wire logic [7:0]          in_char,
  output logic                     raw_we,
  output logic      [AW-1:0]       raw_waddr,
  output logic      [7:0]          raw_wdata,
  output logic                     raw_re,
  output logic      [AW-1:0]       raw_raddr,
  input  wire logic [7:0]          raw_rdata,
  output logic                     cooked_we,
  output logic      [AW-1:0]       cooked_waddr,
  output logic      [7:0]          cooked_wdata,
  output logic                     cooked_re,
  output logic      [AW-1:0]       cooked_raddr,
  input  wire logic [7:0]          cooked_rdata,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output tld_pkg::tld_result_t     res
);

  import tld_pkg::*;

  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
    ring_next = (pos == LAST_POS) ? '0 : pos + 1'b1;
  endfunction

  tld_state_t  state_r, state_nxt;
  logic [AW-1:0] raw_head_r, raw_head_nxt, raw_tail_r, raw_tail_nxt;
  logic [AW-1:0] cooked_head_r, cooked_head_nxt, cooked_tail_r, cooked_tail_nxt;
  tld_result_t res_r, res_nxt;
  logic        raw_empty, raw_full, cooked_empty, cooked_full;
  logic [7:0]  rd_char;

  assign raw_empty    = (raw_head_r == raw_tail_r);
  assign raw_full     = (ring_next(raw_head_r) == raw_tail_r);
  assign cooked_empty = (cooked_head_r == cooked_tail_r);
  assign cooked_full  = (ring_next(cooked_head_r) == cooked_tail_r);
  assign rd_char      = canonical_mode ? cooked_rdata : raw_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      raw_head_r    <= '0;
      raw_tail_r    <= '0;
      cooked_head_r <= '0;
      cooked_tail_r <= '0;
    end else begin
      state_r       <= state_nxt;
      raw_head_r    <= raw_head_nxt;
      raw_tail_r    <= raw_tail_nxt;
      cooked_head_r <= cooked_head_nxt;
      cooked_tail_r <= cooked_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    raw_head_nxt    = raw_head_r;
    raw_tail_nxt    = raw_tail_r;
    cooked_head_nxt = cooked_head_r;
    cooked_tail_nxt = cooked_tail_r;
    res_nxt         = res_r;
    in_stall        = (state_r != ST_IDLE);
    res_valid       = 1'b0;
    raw_we          = 1'b0;
    raw_waddr       = raw_head_r;
    raw_wdata       = in_char;
    raw_re          = 1'b0;
    raw_raddr       = raw_tail_r;
    cooked_we       = 1'b0;
    cooked_waddr    = cooked_head_r;
    cooked_wdata    = raw_rdata;
    cooked_re       = 1'b0;
    cooked_raddr    = cooked_tail_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_action == ACT_KEY) begin
            // Drop the character when the raw ring is full, still echo it if echo is on in canonical mode
            if (raw_full) begin
              res_nxt.char_dropped = 1'b1;
            end else begin
              raw_we       = 1'b1;
              raw_head_nxt = ring_next(raw_head_r);
            end
            if (echo_enable && canonical_mode) begin
              res_nxt.echo_valid = 1'b1;
              res_nxt.echo_char  = in_char;
            end
            state_nxt = (canonical_mode && in_char == NEWLINE_CHAR) ? ST_XFER_RD : ST_RESP;
          end else if (canonical_mode) begin
            if (cooked_empty) begin
              res_nxt.read_empty = 1'b1;
              state_nxt          = ST_RESP;
            end else begin
              cooked_re       = 1'b1;
              cooked_tail_nxt = ring_next(cooked_tail_r);
              state_nxt       = ST_RD_WAIT;
            end
          end else begin
            if (raw_empty) begin
              res_nxt.read_empty = 1'b1;
              state_nxt          = ST_RESP;
            end else begin
              raw_re       = 1'b1;
              raw_tail_nxt = ring_next(raw_tail_r);
              state_nxt    = ST_RD_WAIT;
            end
          end
        end
      end
      ST_XFER_RD: begin
        if (raw_empty || cooked_full) begin
          state_nxt = ST_RESP;
        end else begin
          raw_re       = 1'b1;
          raw_tail_nxt = ring_next(raw_tail_r);
          state_nxt    = ST_XFER_WR;
        end
      end
      ST_XFER_WR: begin
        cooked_we       = 1'b1;
        cooked_head_nxt = ring_next(cooked_head_r);
        state_nxt       = ST_XFER_RD;
      end
      ST_RD_WAIT: begin
        res_nxt.read_valid = 1'b1;
        res_nxt.read_char  = rd_char;
        if (canonical_mode) begin
          res_nxt.line_end = (rd_char == NEWLINE_CHAR);
        end else if (echo_enable) begin
          res_nxt.echo_valid = 1'b1;
          res_nxt.echo_char  = rd_char;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire

/* rtl/core/tty_line_discipline_buffer.sv */
// tty_line_discipline_buffer: top level of the terminal input buffer.
// Holds the configuration registers, two ring stores, the sequencer and the
// result register. Depends on tld_pkg, tld_ring and tld_ctrl.
//
//   Input channel (in_valid / in_stall): in_action selects a key character
//   (in_char is stored in the raw ring unless full) or a read request (one character
//   is popped or empty flagged). Each gives one result on out_valid / out_stall.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 echo enable, 1 canonical mode); write only while the block is idle.
//   Flow: a plain key or an empty read goes from ST_IDLE via ST_RESP into the
//   result register, and the next input is taken back in ST_IDLE; a read that
//   pops adds one ring read (ST_RD_WAIT). A canonical newline moves characters
//   raw to cooked (ST_XFER_RD, ST_XFER_WR) until raw is empty or cooked full.
//   in_stall is high while a transaction is worked on; one item at a time.
//   Stall: hold the result while out_stall is high; the next input is still
//   accepted and waits in the sequencer until the result register frees up.
//   Reset (rst_n low, synchronous): clear all ring pointers, set echo and
//   canonical mode; ring contents are left as they are. No clearing pass.
`default_nettype none

module tty_line_discipline_buffer #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [7:0] in_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_echo_valid,
  output logic      [7:0] out_echo_char,
  output logic            out_read_valid,
  output logic      [7:0] out_read_char,
  output logic            out_read_empty,
  output logic            out_line_end,
  output logic            out_char_dropped
);

  import tld_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic          echo_enable_r, canonical_mode_r;
  logic          raw_we, raw_re, cooked_we, cooked_re;
  logic [AW-1:0] raw_waddr, raw_raddr, cooked_waddr, cooked_raddr;
  logic [7:0]    raw_wdata, raw_rdata, cooked_wdata, cooked_rdata;
  logic          res_valid, res_ready;
  tld_result_t   res;
  logic          out_valid_r;
  tld_result_t   out_res_r;

  // Configuration registers: take a write whenever enabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_enable_r    <= 1'b1;
      canonical_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ECHO_ENABLE:    echo_enable_r    <= cfg_wdata;
        CFG_CANONICAL_MODE: canonical_mode_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  tld_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_raw_ring (
    .clk     (clk),
    .wr_en   (raw_we),
    .wr_addr (raw_waddr),
    .wr_data (raw_wdata),
    .rd_en   (raw_re),
    .rd_addr (raw_raddr),
    .rd_data (raw_rdata)
  );

  tld_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_cooked_ring (
    .clk     (clk),
    .wr_en   (cooked_we),
    .wr_addr (cooked_waddr),
    .wr_data (cooked_wdata),
    .rd_en   (cooked_re),
    .rd_addr (cooked_raddr),
    .rd_data (cooked_rdata)
  );

  tld_ctrl #(.DEPTH(RING_DEPTH), .AW(AW)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .echo_enable    (echo_enable_r),
    .canonical_mode (canonical_mode_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_char        (in_char),
    .raw_we         (raw_we),
    .raw_waddr      (raw_waddr),
    .raw_wdata      (raw_wdata),
    .raw_re         (raw_re),
    .raw_raddr      (raw_raddr),
    .raw_rdata      (raw_rdata),
    .cooked_we      (cooked_we),
    .cooked_waddr   (cooked_waddr),
    .cooked_wdata   (cooked_wdata),
    .cooked_re      (cooked_re),
    .cooked_raddr   (cooked_raddr),
    .cooked_rdata   (cooked_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // Result register: load when empty or when the current transaction leaves
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_echo_valid   = out_res_r.echo_valid;
  assign out_echo_char    = out_res_r.echo_char;
  assign out_read_valid   = out_res_r.read_valid;
  assign out_read_char    = out_res_r.read_char;
  assign out_read_empty   = out_res_r.read_empty;
  assign out_line_end     = out_res_r.line_end;
  assign out_char_dropped = out_res_r.char_dropped;

endmodule

`default_nettype wire

/* rtl/core/tld_checker.sv */
// tld_checker: port-level checks on the line discipline buffer's results,
// bound to the top level. Depends on tld_pkg and tty_line_discipline_buffer.
`default_nettype none

module tld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_echo_valid,
  input wire logic [7:0] out_echo_char,
  input wire logic       out_read_valid,
  input wire logic [7:0] out_read_char,
  input wire logic       out_read_empty,
  input wire logic       out_line_end,
  input wire logic       out_char_dropped
);

  import tld_pkg::*;

  // A stalled result transaction stays and its read character, echo character and read flag do not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_char) &&
      $stable(out_echo_char) && $stable(out_read_valid))
    else $error("result changed while stalled");

  // A read either pops or reports empty, never both
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_valid && out_read_empty))
    else $error("read both valid and empty");

  // A dropped key never carries read flags
  a_drop_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_dropped |-> !out_read_valid && !out_read_empty)
    else $error("drop flag on a read result");

  // Line end only on a popped newline
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_read_valid && (out_read_char == NEWLINE_CHAR))
    else $error("line end without a newline");

  // A raw read echoes the very character it pops
  a_echo_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid && out_read_valid |-> out_echo_char == out_read_char)
    else $error("echo differs from popped character");

endmodule

bind tty_line_discipline_buffer tld_checker u_tld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_echo_valid   (out_echo_valid),
  .out_echo_char    (out_echo_char),
  .out_read_valid   (out_read_valid),
  .out_read_char    (out_read_char),
  .out_read_empty   (out_read_empty),
  .out_line_end     (out_line_end),
  .out_char_dropped (out_char_dropped)
);

`default_nettype wire
